### src/sfu_pkg.sv
package sfu_pkg;

  localparam int MAX_FRAME_BYTES = 4096;

  localparam logic [7:0] SIR_BOF   = 8'hC0;
  localparam logic [7:0] SIR_EOF   = 8'hC1;
  localparam logic [7:0] SIR_CE    = 8'h7D;
  localparam logic [7:0] SIR_XBOF  = 8'hFF;
  localparam logic [7:0] SIR_TRANS = 8'h20;

  localparam logic [15:0] FCS_INIT = 16'hFFFF;
  localparam logic [15:0] FCS_GOOD = 16'hF0B8;
  localparam logic [15:0] FCS_POLY = 16'h8408;

  localparam logic [12:0] MAX_LEN_RESET = 13'd4096;

  typedef enum logic [3:0] {
    PH_OUTSIDE = 4'b0001,
    PH_BEGIN   = 4'b0010,
    PH_ESCAPE  = 4'b0100,
    PH_INSIDE  = 4'b1000
  } phase_t;

  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_DATA     = 3'd1,
    EV_GOOD     = 3'd2,
    EV_CRCERR   = 3'd3,
    EV_ABORT    = 3'd4,
    EV_ESCABORT = 3'd5,
    EV_OVERFLOW = 3'd6,
    EV_DISCARD  = 3'd7
  } event_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] rx_byte;
  } stage_t;

  function automatic logic [15:0] fcs_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ FCS_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  function automatic logic [12:0] frame_limit(input logic [12:0] max_len);
    if (32'(max_len) > MAX_FRAME_BYTES) begin
      return 13'(MAX_FRAME_BYTES);
    end
    return max_len;
  endfunction

endpackage

### src/sfu_in_if.sv
interface sfu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

### src/sfu_out_if.sv
interface sfu_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_res;
  logic [7:0]  data_byte;
  logic [11:0] byte_index;
  logic [12:0] frame_length;
  logic        media_busy;
  logic        frame_active;

  modport source (output valid, output event_res, output data_byte, output byte_index,
                  output frame_length, output media_busy, output frame_active, input ready);
  modport sink (input valid, input event_res, input data_byte, input byte_index,
                input frame_length, input media_busy, input frame_active, output ready);
endinterface

### src/sir_frame_unwrapper.sv
// SIR receive deframer. Each received line word yields exactly one result word: a de-stuffed
// data byte with its index in the frame, a no-event word, or an end-of-frame status (good,
// CRC error, abort, escape abort, overflow, discarded by a new BOF), plus media-busy and
// frame-active flags. The FCS-16 is checked on the fly and the payload is streamed, so the
// consumer must drop every frame whose status is not good. Throughput is one word per clock
// while the result side is not stalled by a low ready; an accepted word is held in the input
// register, and its phase/FCS update is then loaded into the result register. The per-word
// FCS fold, byte count and phase update form the single loop that sets this rate.
// max_frame_len may only be written while no words are in flight.
module sir_frame_unwrapper (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [12:0] cfg_data,
  sfu_in_if.sink      rx,
  sfu_out_if.source   res
);
  import sfu_pkg::*;

  stage_t stage;
  logic   advance;

  sfu_in_reg u_in_reg (
    .clk     (clk),
    .rst     (rst),
    .rx      (rx),
    .advance (advance),
    .stage   (stage)
  );

  sfu_core u_core (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .stage    (stage),
    .advance  (advance),
    .res      (res)
  );
endmodule

### src/sfu_in_reg.sv
module sfu_in_reg (
  input  logic            clk,
  input  logic            rst,
  sfu_in_if.sink          rx,
  input  logic            advance,
  output sfu_pkg::stage_t stage
);
  import sfu_pkg::*;

  assign rx.ready = !stage.valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else if (rx.ready) begin
      stage.valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.ready && rx.valid) begin
      stage.rx_byte <= rx.rx_byte;
    end
  end
endmodule

### src/sfu_core.sv
module sfu_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [12:0]     cfg_data,
  input  sfu_pkg::stage_t stage,
  output logic            advance,
  sfu_out_if.source       res
);
  import sfu_pkg::*;

  logic [12:0] max_frame_len;
  phase_t      phase, phase_next;
  logic [12:0] byte_count, byte_count_next;
  logic [15:0] crc_accum, crc_accum_next;
  logic        open_flag, open_flag_next;

  logic [12:0] cnt_eff;
  logic [15:0] crc_eff;
  logic [7:0]  b;
  logic        take_data;
  event_t      ev;
  logic [7:0]  dout;
  logic [11:0] idx;
  logic [12:0] flen;
  logic        busy;
  logic        fire;

  assign advance = !res.valid || res.ready;
  assign fire    = advance && stage.valid;

  always_comb begin
    phase_next      = phase;
    byte_count_next = byte_count;
    crc_accum_next  = crc_accum;
    open_flag_next  = open_flag;
    cnt_eff         = byte_count;
    crc_eff         = crc_accum;
    b               = stage.rx_byte;
    take_data       = 1'b0;
    ev              = EV_NONE;
    dout            = 8'h00;
    idx             = 12'h000;
    flen            = 13'h0000;
    busy            = 1'b0;

    unique case (phase)
      PH_BEGIN: begin
        cnt_eff         = 13'h0000;
        crc_eff         = FCS_INIT;
        byte_count_next = 13'h0000;
        crc_accum_next  = FCS_INIT;
        priority if (b == SIR_BOF) begin
        end else if (b == SIR_CE) begin
          phase_next = PH_ESCAPE;
        end else if (b == SIR_EOF) begin
          phase_next     = PH_OUTSIDE;
          open_flag_next = 1'b0;
          ev             = EV_ABORT;
        end else begin
          take_data = 1'b1;
        end
      end
      PH_ESCAPE: begin
        priority if (b == SIR_BOF) begin
          phase_next = PH_BEGIN;
          busy       = 1'b1;
          ev         = EV_DISCARD;
        end else if (b == SIR_CE) begin
        end else if (b == SIR_EOF) begin
          phase_next     = PH_OUTSIDE;
          open_flag_next = 1'b0;
          ev             = EV_ESCABORT;
        end else begin
          b         = stage.rx_byte ^ SIR_TRANS;
          take_data = 1'b1;
        end
      end
      PH_INSIDE: begin
        priority if (b == SIR_BOF) begin
          phase_next = PH_BEGIN;
          busy       = 1'b1;
          ev         = EV_DISCARD;
        end else if (b == SIR_CE) begin
          phase_next = PH_ESCAPE;
        end else if (b == SIR_EOF) begin
          phase_next     = PH_OUTSIDE;
          open_flag_next = 1'b0;
          if (crc_accum == FCS_GOOD) begin
            ev   = EV_GOOD;
            flen = (byte_count >= 13'd2) ? byte_count - 13'd2 : 13'h0000;
          end else begin
            ev   = EV_CRCERR;
            busy = 1'b1;
          end
        end else begin
          take_data = 1'b1;
        end
      end
      default: begin
        // outside, and any unreachable code
        phase_next = PH_OUTSIDE;
        if (b == SIR_BOF) begin
          phase_next     = PH_BEGIN;
          open_flag_next = 1'b1;
        end else if (b != SIR_XBOF) begin
          busy = 1'b1;
        end
      end
    endcase

    if (take_data) begin
      if (cnt_eff < frame_limit(max_frame_len)) begin
        ev              = EV_DATA;
        dout            = b;
        idx             = cnt_eff[11:0];
        crc_accum_next  = fcs_update(crc_eff, b);
        byte_count_next = cnt_eff + 13'd1;
        phase_next      = PH_INSIDE;
      end else begin
        ev             = EV_OVERFLOW;
        phase_next     = PH_OUTSIDE;
        open_flag_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_frame_len <= MAX_LEN_RESET;
      phase         <= PH_OUTSIDE;
      byte_count    <= 13'h0000;
      crc_accum     <= FCS_INIT;
      open_flag     <= 1'b0;
      res.valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        max_frame_len <= cfg_data;
      end
      if (fire) begin
        phase      <= phase_next;
        byte_count <= byte_count_next;
        crc_accum  <= crc_accum_next;
        open_flag  <= open_flag_next;
      end
      if (advance) begin
        res.valid <= stage.valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res.event_res    <= ev;
      res.data_byte    <= dout;
      res.byte_index   <= idx;
      res.frame_length <= flen;
      res.media_busy   <= busy;
      res.frame_active <= open_flag_next;
    end
  end
endmodule

### src/sfu_checker.sv
module sfu_checker (
  input logic        clk,
  input logic        rst,
  input logic        res_valid,
  input logic        res_ready,
  input logic [2:0]  event_res,
  input logic [7:0]  data_byte,
  input logic [11:0] byte_index,
  input logic [12:0] frame_length,
  input logic        frame_active
);
  import sfu_pkg::*;

  // stalled result word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(event_res) && $stable(data_byte)
      && $stable(byte_index) && $stable(frame_length) && $stable(frame_active))
    else $error("result word changed while stalled");

  a_data_open: assert property (@(posedge clk) disable iff (rst)
    res_valid && event_res == EV_DATA |-> frame_active)
    else $error("data word outside frame");

  a_close: assert property (@(posedge clk) disable iff (rst)
    res_valid && (event_res == EV_GOOD || event_res == EV_CRCERR || event_res == EV_ABORT
      || event_res == EV_ESCABORT || event_res == EV_OVERFLOW) |-> !frame_active)
    else $error("frame still open after end status");

  a_payload_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && event_res != EV_DATA |-> data_byte == 8'h00 && byte_index == 12'h000
      && (event_res == EV_GOOD || frame_length == 13'h0000))
    else $error("stray payload on status word");
endmodule

bind sir_frame_unwrapper sfu_checker u_sfu_checker (
  .clk          (clk),
  .rst          (rst),
  .res_valid    (res.valid),
  .res_ready    (res.ready),
  .event_res    (res.event_res),
  .data_byte    (res.data_byte),
  .byte_index   (res.byte_index),
  .frame_length (res.frame_length),
  .frame_active (res.frame_active)
);
